>>> src/tpq_pkg.sv
package tpq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned TicketW    = 16;
  localparam int unsigned IdW        = 16;
  localparam int unsigned FillW      = $clog2(QueueDepth + 1);
  localparam int unsigned CountW     = 5;
  localparam int unsigned TicketOutW = 16;
  localparam int unsigned ReqW       = 2;
  localparam int unsigned StatusW    = 2;

  localparam logic [ReqW-1:0] ReqEnqNormal = 2'd0;
  localparam logic [ReqW-1:0] ReqEnqPrio   = 2'd1;
  localparam logic [ReqW-1:0] ReqServe     = 2'd2;

  typedef enum logic [StatusW-1:0] {
    StatOk    = 2'd0,
    StatFull  = 2'd1,
    StatEmpty = 2'd2
  } status_e;

  typedef struct packed {
    logic [IdW-1:0]     id;
    logic [TicketW-1:0] ticket;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    logic           push;
    logic           pop;
    logic [IdW-1:0] id;
  } lane_ctrl_t;

  typedef struct packed {
    entry_t             head;
    logic [FillW-1:0]   fill;
    logic               full;
    logic               empty;
    logic [TicketW-1:0] next_ticket;
  } lane_stat_t;

endpackage

>>> src/tpq_cell.sv
module tpq_cell (
  input  logic                clk_i,
  input  tpq_pkg::cell_ctrl_t ctrl_i,
  input  tpq_pkg::entry_t     load_data_i,
  input  tpq_pkg::entry_t     next_data_i,
  output tpq_pkg::entry_t     data_o
);
  import tpq_pkg::*;

  entry_t data_q;

  // pop moves the whole row one cell toward the head
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      data_q <= next_data_i;
    end else if (ctrl_i.load) begin
      data_q <= load_data_i;
    end
  end

  assign data_o = data_q;

endmodule

>>> src/tpq_lane.sv
module tpq_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tpq_pkg::lane_ctrl_t ctrl_i,
  output tpq_pkg::lane_stat_t stat_o
);
  import tpq_pkg::*;

  logic [FillW-1:0]   fill_q, fill_d;
  logic [TicketW-1:0] counter_q, counter_d;
  logic [TicketW-1:0] next_ticket;
  entry_t             new_entry;
  entry_t             cell_data [QueueDepth];

  assign next_ticket     = counter_q + TicketW'(1);
  assign new_entry.id     = ctrl_i.id;
  assign new_entry.ticket = next_ticket;

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    cell_ctrl_t cctrl;
    entry_t     nbr;

    assign cctrl.shift = ctrl_i.pop;
    assign cctrl.load  = ctrl_i.push && (fill_q == FillW'(i));

    if (i == QueueDepth - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_data[i+1];
    end

    tpq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cctrl),
      .load_data_i (new_entry),
      .next_data_i (nbr),
      .data_o      (cell_data[i])
    );
  end

  always_comb begin
    fill_d    = fill_q;
    counter_d = counter_q;
    if (ctrl_i.push) begin
      fill_d    = fill_q + FillW'(1);
      counter_d = next_ticket;
    end else if (ctrl_i.pop) begin
      fill_d    = fill_q - FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      counter_q <= '0;
    end else begin
      fill_q    <= fill_d;
      counter_q <= counter_d;
    end
  end

  assign stat_o.head        = cell_data[0];
  assign stat_o.fill        = fill_q;
  assign stat_o.full        = (fill_q == FillW'(QueueDepth));
  assign stat_o.empty       = (fill_q == '0);
  assign stat_o.next_ticket = next_ticket;

endmodule

>>> src/two_class_priority_ticket_queue_unit.sv
// an accepted word's result is registered into the output register and shows at the output in the next cycle
// throughput: one word per cycle while in_ready_o is high; each class is a row of shift cells, head at cell zero
// a result waiting in the output register does not block input while out_ready_i is high
// reset: fills and ticket counters clear, output valid drops; stored entries are not cleared
module two_class_priority_ticket_queue_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [tpq_pkg::ReqW-1:0]     req_type_i,
  input  logic [tpq_pkg::IdW-1:0]      client_id_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tpq_pkg::StatusW-1:0]  status_o,
  output logic [tpq_pkg::TicketOutW-1:0] ticket_o,
  output logic [tpq_pkg::IdW-1:0]      served_id_o,
  output logic                         from_priority_o,
  output logic [tpq_pkg::CountW-1:0]   normal_count_o,
  output logic [tpq_pkg::CountW-1:0]   priority_count_o
);
  import tpq_pkg::*;

  lane_ctrl_t n_ctrl, p_ctrl;
  lane_stat_t n_stat, p_stat;

  logic                  accept;
  logic                  out_valid_q, out_valid_d;
  status_e               status_q, status_d;
  logic [TicketW-1:0]    ticket_q, ticket_d;
  logic [IdW-1:0]        sid_q, sid_d;
  logic                  prio_q, prio_d;
  logic [FillW-1:0]      ncnt_q, ncnt_d, pcnt_q, pcnt_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  tpq_lane u_normal (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (n_ctrl),
    .stat_o (n_stat)
  );

  tpq_lane u_prio (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (p_ctrl),
    .stat_o (p_stat)
  );

  always_comb begin
    n_ctrl      = '{push: 1'b0, pop: 1'b0, id: client_id_i};
    p_ctrl      = '{push: 1'b0, pop: 1'b0, id: client_id_i};
    status_d    = StatOk;
    ticket_d    = '0;
    sid_d       = '0;
    prio_d      = 1'b0;
    ncnt_d      = n_stat.fill;
    pcnt_d      = p_stat.fill;
    case (req_type_i)
      ReqEnqNormal: begin
        if (n_stat.full) begin
          status_d = StatFull;
        end else begin
          n_ctrl.push = accept;
          ticket_d    = n_stat.next_ticket;
          ncnt_d      = n_stat.fill + FillW'(1);
        end
      end
      ReqEnqPrio: begin
        prio_d = 1'b1;
        if (p_stat.full) begin
          status_d = StatFull;
        end else begin
          p_ctrl.push = accept;
          ticket_d    = p_stat.next_ticket;
          pcnt_d      = p_stat.fill + FillW'(1);
        end
      end
      default: begin
        // serve: priority class first
        if (!p_stat.empty) begin
          p_ctrl.pop = accept;
          ticket_d   = p_stat.head.ticket;
          sid_d      = p_stat.head.id;
          prio_d     = 1'b1;
          pcnt_d     = p_stat.fill - FillW'(1);
        end else if (!n_stat.empty) begin
          n_ctrl.pop = accept;
          ticket_d   = n_stat.head.ticket;
          sid_d      = n_stat.head.id;
          ncnt_d     = n_stat.fill - FillW'(1);
        end else begin
          status_d = StatEmpty;
        end
      end
    endcase
  end

  assign out_valid_d = accept || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      ticket_q <= ticket_d;
      sid_q    <= sid_d;
      prio_q   <= prio_d;
      ncnt_q   <= ncnt_d;
      pcnt_q   <= pcnt_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign ticket_o         = TicketOutW'(ticket_q);
  assign served_id_o      = sid_q;
  assign from_priority_o  = prio_q;
  assign normal_count_o   = CountW'(ncnt_q);
  assign priority_count_o = CountW'(pcnt_q);

  a_accept_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted word produced no result");

  a_empty_means_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == StatEmpty) |->
      (normal_count_o == '0 && priority_count_o == '0 && served_id_o == '0))
    else $error("empty status with waiting entries");

  a_full_no_ticket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == StatFull) |-> (ticket_o == '0 && served_id_o == '0))
    else $error("refused enqueue carries a ticket");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_stat.fill <= FillW'(QueueDepth)) && (p_stat.fill <= FillW'(QueueDepth)))
    else $error("fill count beyond queue depth");

  a_one_lane_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({n_ctrl.push, n_ctrl.pop, p_ctrl.push, p_ctrl.pop}) <= 1)
    else $error("more than one lane changed in one word");

endmodule
